/* design/fblr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fblr_pkg;

    localparam int WIDTH_DEF  = 128;
    localparam int HEIGHT_DEF = 32;

    localparam int CW = 12;

    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_INIT,
        S_PLOT,
        S_WRITE,
        S_RDWAIT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* design/framebuffer_line_rasterizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   valid      ready      payload
// request   req_valid  req_ready  operation, x_start, y_start, x_end, y_end, color, read_index
// result    res_valid  res_ready  read_data, completed_operation
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Line: S_SETUP, S_INIT and S_DONE, plus a RAM read then a write per on-screen pixel
//   and a step with no RAM access per clipped pixel, all through one shared step unit.
// Clear: one byte per cycle over the whole store. Read: RAM read in S_IDLE, taken in S_RDWAIT.
// After reset a clearing pass over all WIDTH*ceil(HEIGHT/8) bytes (512 by default)
//   runs before req_ready rises. The result register lets a new request be
//   taken while the previous result waits; a finished request waits for it.
module framebuffer_line_rasterizer_top #(
    parameter int WIDTH  = fblr_pkg::WIDTH_DEF,
    parameter int HEIGHT = fblr_pkg::HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [1:0]                    operation,
    input  wire logic signed [fblr_pkg::CW-1:0] x_start,
    input  wire logic signed [fblr_pkg::CW-1:0] y_start,
    input  wire logic signed [fblr_pkg::CW-1:0] x_end,
    input  wire logic signed [fblr_pkg::CW-1:0] y_end,
    input  wire logic                          color,
    input  wire logic [8:0]                    read_index,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [7:0]                         read_data,
    output logic [1:0]                         completed_operation
);

    localparam int PAGES       = (HEIGHT + 7) / 8;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int IW          = ((AW > 9) ? AW : 9) + 1;
    localparam int CW          = fblr_pkg::CW;
    localparam logic [CW-1:0] WIDTH_C  = CW'(WIDTH);
    localparam logic [CW-1:0] HEIGHT_C = CW'(HEIGHT);

    fblr_pkg::state_t state_reg, state_next;

    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 clr_reply_reg, clr_reply_next;
    logic                 res_valid_reg;
    logic [7:0]           read_data_reg;
    logic [1:0]           completed_reg;

    logic [1:0]           op_reg, op_next;
    logic signed [CW-1:0] cur_x_reg, cur_x_next;
    logic signed [CW-1:0] cur_y_reg, cur_y_next;
    logic signed [CW-1:0] x_end_reg, x_end_next;
    logic signed [CW-1:0] y_end_reg, y_end_next;
    logic                 color_reg, color_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic signed [12:0]   dx_reg, dx_next;
    logic signed [12:0]   dy_reg, dy_next;
    logic                 sx_neg_reg, sx_neg_next;
    logic                 sy_neg_reg, sy_neg_next;
    logic signed [15:0]   err_reg, err_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    logic [7:0]           result_reg, result_next;

    logic [7:0]           mem [STORE_BYTES];
    logic [7:0]           mem_rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [7:0]           mem_wdata;

    logic                 res_load;

    logic [IW-1:0]        ri_ext;
    logic                 rd_in_range;
    logic [AW-1:0]        rd_idx_addr;
    logic [AW-1:0]        pix_addr;
    logic                 on_screen;
    logic [7:0]           pix_mask;

    logic signed [16:0]   e2;
    logic                 step_x;
    logic                 step_y;
    logic                 step_done;
    logic signed [15:0]   err_step;
    logic signed [CW-1:0] x_step;
    logic signed [CW-1:0] y_step;

    logic signed [CW:0]   dxp, dxn, dyp, dyn;
    logic                 reject;

    assign ri_ext      = IW'(read_index);
    assign rd_in_range = ri_ext < IW'(STORE_BYTES);
    assign rd_idx_addr = ri_ext[AW-1:0];

    assign on_screen = !cur_x_reg[CW-1] && ($unsigned(cur_x_reg) < WIDTH_C)
                    && !cur_y_reg[CW-1] && ($unsigned(cur_y_reg) < HEIGHT_C);
    assign pix_addr  = AW'($unsigned(cur_x_reg))
                     + AW'(AW'(WIDTH) * AW'($unsigned(cur_y_reg) >> 3));
    assign pix_mask  = 8'b1 << cur_y_reg[2:0];

    // shared Bresenham step
    assign e2        = $signed({err_reg, 1'b0});
    assign step_x    = e2 >= 17'(dy_reg);
    assign step_y    = e2 <= 17'(dx_reg);
    assign step_done = ((cur_x_reg == x_end_reg) && (cur_y_reg == y_end_reg))
                    || (step_x && (cur_x_reg == x_end_reg))
                    || (step_y && (cur_y_reg == y_end_reg));
    assign err_step  = err_reg + (step_x ? 16'(dy_reg) : 16'sd0)
                               + (step_y ? 16'(dx_reg) : 16'sd0);
    assign x_step    = step_x ? (cur_x_reg + (sx_neg_reg ? -12'sd1 : 12'sd1)) : cur_x_reg;
    assign y_step    = step_y ? (cur_y_reg + (sy_neg_reg ? -12'sd1 : 12'sd1)) : cur_y_reg;

    assign dxp    = (CW+1)'(x_end_reg) - (CW+1)'(cur_x_reg);
    assign dxn    = (CW+1)'(cur_x_reg) - (CW+1)'(x_end_reg);
    assign dyp    = (CW+1)'(y_end_reg) - (CW+1)'(cur_y_reg);
    assign dyn    = (CW+1)'(cur_y_reg) - (CW+1)'(y_end_reg);
    assign reject = ((cur_y_reg == y_end_reg) && (cur_x_reg > x_end_reg))
                 || ((cur_x_reg == x_end_reg) && (cur_y_reg != y_end_reg)
                     && (cur_y_reg > y_end_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        op_next        = op_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        color_next     = color_reg;
        rd_ok_next     = rd_ok_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        err_next       = err_reg;
        wr_addr_next   = wr_addr_reg;
        result_next    = result_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_cnt_reg;
        mem_wdata      = 8'h00;
        mem_raddr      = pix_addr;
        req_ready      = 1'b0;
        res_load       = 1'b0;

        unique case (state_reg)
            fblr_pkg::S_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                result_next  = 8'h00;
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_reply_reg ? fblr_pkg::S_DONE : fblr_pkg::S_IDLE;
                end
            end
            fblr_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                mem_raddr = rd_idx_addr;
                if (req_valid)
                begin
                    op_next     = operation;
                    cur_x_next  = x_start;
                    cur_y_next  = y_start;
                    x_end_next  = x_end;
                    y_end_next  = y_end;
                    color_next  = color;
                    rd_ok_next  = rd_in_range;
                    result_next = 8'h00;
                    unique case (operation)
                        fblr_pkg::OP_LINE:
                            state_next = fblr_pkg::S_SETUP;
                        fblr_pkg::OP_CLEAR:
                        begin
                            clr_reply_next = 1'b1;
                            clr_cnt_next   = '0;
                            state_next     = fblr_pkg::S_CLEAR;
                        end
                        fblr_pkg::OP_READ:
                            state_next = fblr_pkg::S_RDWAIT;
                        default:
                            state_next = fblr_pkg::S_DONE;
                    endcase
                end
            end
            fblr_pkg::S_RDWAIT:
            begin
                result_next = rd_ok_reg ? mem_rdata_reg : 8'h00;
                state_next  = fblr_pkg::S_DONE;
            end
            fblr_pkg::S_SETUP:
            begin
                sx_neg_next = !(cur_x_reg < x_end_reg);
                sy_neg_next = !(cur_y_reg < y_end_reg);
                dx_next     = (cur_x_reg < x_end_reg) ? dxp : dxn;
                dy_next     = (cur_y_reg < y_end_reg) ? dyn : dyp;
                state_next  = reject ? fblr_pkg::S_DONE : fblr_pkg::S_INIT;
            end
            fblr_pkg::S_INIT:
            begin
                err_next   = 16'(dx_reg) + 16'(dy_reg);
                state_next = fblr_pkg::S_PLOT;
            end
            fblr_pkg::S_PLOT:
            begin
                if (on_screen)
                begin
                    wr_addr_next = pix_addr;
                    state_next   = fblr_pkg::S_WRITE;
                end
                else if (step_done)
                begin
                    state_next = fblr_pkg::S_DONE;
                end
                else
                begin
                    cur_x_next = x_step;
                    cur_y_next = y_step;
                    err_next   = err_step;
                end
            end
            fblr_pkg::S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_addr_reg;
                mem_wdata = color_reg ? (mem_rdata_reg | pix_mask)
                                      : (mem_rdata_reg & ~pix_mask);
                if (step_done)
                begin
                    state_next = fblr_pkg::S_DONE;
                end
                else
                begin
                    cur_x_next = x_step;
                    cur_y_next = y_step;
                    err_next   = err_step;
                    state_next = fblr_pkg::S_PLOT;
                end
            end
            fblr_pkg::S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_load   = 1'b1;
                    state_next = fblr_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fblr_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        x_end_reg   <= x_end_next;
        y_end_reg   <= y_end_next;
        color_reg   <= color_next;
        rd_ok_reg   <= rd_ok_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sx_neg_reg  <= sx_neg_next;
        sy_neg_reg  <= sy_neg_next;
        err_reg     <= err_next;
        wr_addr_reg <= wr_addr_next;
        result_reg  <= result_next;
        if (res_load)
        begin
            read_data_reg <= result_reg;
            completed_reg <= op_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign res_valid           = res_valid_reg;
    assign read_data           = read_data_reg;
    assign completed_operation = completed_reg;

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == fblr_pkg::S_CLEAR || state_reg == fblr_pkg::S_WRITE))
        else $error("store written outside clear or pixel write");

    a_we_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (32'(mem_waddr) < STORE_BYTES))
        else $error("store write beyond last byte");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!res_valid_reg || res_ready))
        else $error("result register overwritten");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && completed_operation != fblr_pkg::OP_READ) |-> (read_data == 8'h00))
        else $error("nonzero data on non-read result");

endmodule

`default_nettype wire

/* test/fblr_checker.sv */
`timescale 1ns / 1ps

module fblr_checker #(
    parameter int WIDTH  = fblr_pkg::WIDTH_DEF,
    parameter int HEIGHT = fblr_pkg::HEIGHT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    input  wire logic                           req_ready,
    input  wire logic [1:0]                     operation,
    input  wire logic signed [fblr_pkg::CW-1:0] x_start,
    input  wire logic signed [fblr_pkg::CW-1:0] y_start,
    input  wire logic signed [fblr_pkg::CW-1:0] x_end,
    input  wire logic signed [fblr_pkg::CW-1:0] y_end,
    input  wire logic                           color,
    input  wire logic [8:0]                     read_index,
    input  wire logic                           res_valid,
    input  wire logic                           res_ready,
    input  wire logic [7:0]                     read_data,
    input  wire logic [1:0]                     completed_operation,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int PAGES      = (HEIGHT + 7) / 8;
    localparam int STORE_SIZE = WIDTH * PAGES;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] op;
    } readback_t;

    logic [7:0] shadow_fb [0:STORE_SIZE-1];
    readback_t  readback_q [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        for (int i = 0; i < STORE_SIZE; i++)
            shadow_fb[i] = 8'h00;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic plot_px(input int x, input int y, input bit c);
        int idx;
        if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT)
            return;
        idx = x + WIDTH * (y / 8);
        shadow_fb[idx][y % 8] = c;
    endtask

    task automatic draw_segment(input int xa, input int ya, input int xb, input int yb,
                                input bit c);
        int x0, y0, dx, dy, sx, sy, err, e2;
        x0 = xa;
        y0 = ya;
        if (ya == yb)
        begin
            for (int i = xa; i <= xb; i++)
                plot_px(i, ya, c);
            return;
        end
        if (xa == xb)
        begin
            for (int i = ya; i <= yb; i++)
                plot_px(xa, i, c);
            return;
        end
        dx  = (xa < xb) ? xb - xa : xa - xb;
        sx  = (xa < xb) ? 1 : -1;
        dy  = (ya < yb) ? ya - yb : yb - ya;
        sy  = (ya < yb) ? 1 : -1;
        err = dx + dy;
        forever
        begin
            plot_px(x0, y0, c);
            if (x0 == xb && y0 == yb)
                break;
            e2 = 2 * err;
            if (e2 >= dy)
            begin
                if (x0 == xb)
                    break;
                err += dy;
                x0  += sx;
            end
            if (e2 <= dx)
            begin
                if (y0 == yb)
                    break;
                err += dx;
                y0  += sy;
            end
        end
    endtask

    task automatic raster_apply(output readback_t r);
        int xs, ys, xe, ye;
        xs     = int'(x_start);
        ys     = int'(y_start);
        xe     = int'(x_end);
        ye     = int'(y_end);
        r.op   = operation;
        r.data = 8'h00;
        case (operation)
            fblr_pkg::OP_LINE:
                draw_segment(xs, ys, xe, ye, color);
            fblr_pkg::OP_CLEAR:
                for (int i = 0; i < STORE_SIZE; i++)
                    shadow_fb[i] = 8'h00;
            fblr_pkg::OP_READ:
                if (int'(read_index) < STORE_SIZE)
                    r.data = shadow_fb[read_index];
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        readback_t got_exp;
        readback_t fresh;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (readback_q.size() == 0)
                    report_mismatch($sformatf("unexpected result data %02h op %0d",
                                              read_data, completed_operation));
                else
                begin
                    got_exp = readback_q.pop_front();
                    if (completed_operation !== got_exp.op)
                        report_mismatch($sformatf("completed_operation %0d, expected %0d",
                                                  completed_operation, got_exp.op));
                    if (read_data !== got_exp.data)
                        report_mismatch($sformatf("read_data %02h, expected %02h (op %0d)",
                                                  read_data, got_exp.data, got_exp.op));
                end
            end
            if (req_valid && req_ready)
            begin
                raster_apply(fresh);
                readback_q.push_back(fresh);
            end
            outstanding = readback_q.size();
        end
    end

endmodule

/* test/framebuffer_line_rasterizer_top_tb.sv */
`timescale 1ns / 1ps

module framebuffer_line_rasterizer_top_tb;

    localparam int WIDTH       = fblr_pkg::WIDTH_DEF;
    localparam int HEIGHT      = fblr_pkg::HEIGHT_DEF;
    localparam int STORE_SIZE  = WIDTH * ((HEIGHT + 7) / 8);
    localparam int RANDOM_REQS = 925;
    localparam int QUIET_FROM  = 780;
    localparam int IDLE_LIMIT  = 60000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                    op;
        logic signed [fblr_pkg::CW-1:0] xs;
        logic signed [fblr_pkg::CW-1:0] ys;
        logic signed [fblr_pkg::CW-1:0] xe;
        logic signed [fblr_pkg::CW-1:0] ye;
        logic                          c;
        logic [8:0]                    idx;
    } draw_req_t;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_ready;
    logic [1:0]                     operation;
    logic signed [fblr_pkg::CW-1:0] x_start;
    logic signed [fblr_pkg::CW-1:0] y_start;
    logic signed [fblr_pkg::CW-1:0] x_end;
    logic signed [fblr_pkg::CW-1:0] y_end;
    logic                           color;
    logic [8:0]                     read_index;
    logic                           res_valid;
    logic                           res_ready;
    logic [7:0]                     read_data;
    logic [1:0]                     completed_operation;
    int                             mismatches;
    int                             outstanding;
    bit                             quiet;
    int                             stall_left;
    int                             idle_cycles;

    framebuffer_line_rasterizer_top #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .operation           (operation),
        .x_start             (x_start),
        .y_start             (y_start),
        .x_end               (x_end),
        .y_end               (y_end),
        .color               (color),
        .read_index          (read_index),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .read_data           (read_data),
        .completed_operation (completed_operation)
    );

    fblr_checker #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) checker_i (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_ready           (req_ready),
        .operation           (operation),
        .x_start             (x_start),
        .y_start             (y_start),
        .x_end               (x_end),
        .y_end               (y_end),
        .color               (color),
        .read_index          (read_index),
        .res_valid           (res_valid),
        .res_ready           (res_ready),
        .read_data           (read_data),
        .completed_operation (completed_operation),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        operation   = fblr_pkg::OP_READ;
        x_start     = '0;
        y_start     = '0;
        x_end       = '0;
        y_end       = '0;
        color       = 1'b0;
        read_index  = '0;
        res_ready   = 1'b0;
        quiet       = 1'b0;
        stall_left  = 0;
        idle_cycles = 0;
    end

    always #5 clk = ~clk;

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_ready <= 1'b0;
        end
        else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** framebuffer_line_rasterizer_top: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input draw_req_t r);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        operation  <= r.op;
        x_start    <= r.xs;
        y_start    <= r.ys;
        x_end      <= r.xe;
        y_end      <= r.ye;
        color      <= r.c;
        read_index <= r.idx;
        req_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    function automatic draw_req_t noise_req(input logic [1:0] op);
        draw_req_t   r;
        logic [31:0] rnd_a;
        logic [31:0] rnd_b;
        logic [31:0] rnd_c;
        rnd_a = $urandom;
        rnd_b = $urandom;
        rnd_c = $urandom;
        r.op  = op;
        r.xs  = rnd_a[fblr_pkg::CW-1:0];
        r.ys  = rnd_a[2*fblr_pkg::CW-1:fblr_pkg::CW];
        r.xe  = rnd_b[fblr_pkg::CW-1:0];
        r.ye  = rnd_b[2*fblr_pkg::CW-1:fblr_pkg::CW];
        r.c   = rnd_c[9];
        r.idx = rnd_c[8:0];
        return r;
    endfunction

    task automatic line_req(input int xs, input int ys, input int xe, input int ye,
                            input bit c);
        draw_req_t r;
        r    = noise_req(fblr_pkg::OP_LINE);
        r.xs = xs[fblr_pkg::CW-1:0];
        r.ys = ys[fblr_pkg::CW-1:0];
        r.xe = xe[fblr_pkg::CW-1:0];
        r.ye = ye[fblr_pkg::CW-1:0];
        r.c  = c;
        send_request(r);
    endtask

    task automatic read_req(input int idx);
        draw_req_t r;
        r     = noise_req(fblr_pkg::OP_READ);
        r.idx = idx[8:0];
        send_request(r);
    endtask

    function automatic int near_col();
        return $urandom_range(0, WIDTH + 15) - 8;
    endfunction

    function automatic int near_row();
        return $urandom_range(0, HEIGHT + 15) - 8;
    endfunction

    task automatic random_line();
        draw_req_t r;
        int        xs, ys, xe, ye;
        int        kind;
        r    = noise_req(fblr_pkg::OP_LINE);
        kind = $urandom_range(0, 99);
        xs   = near_col();
        ys   = near_row();
        xe   = near_col();
        ye   = near_row();
        if (kind < 20)
            ye = ys;
        else if (kind < 40)
            xe = xs;
        else if (kind < 45)
        begin
            xe = xs;
            ye = ys;
        end
        else if (kind < 50)
        begin
            xe = xs + $urandom_range(0, 6) - 3;
            ye = ys + $urandom_range(0, 6) - 3;
        end
        if (kind >= 96)
            send_request(r);
        else
        begin
            r.xs = xs[fblr_pkg::CW-1:0];
            r.ys = ys[fblr_pkg::CW-1:0];
            r.xe = xe[fblr_pkg::CW-1:0];
            r.ye = ye[fblr_pkg::CW-1:0];
            send_request(r);
        end
    endtask

    initial
    begin
        int pick;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        read_req(0);
        line_req(0, 0, 0, 0, 1'b1);
        read_req(0);
        line_req(-5, HEIGHT - 1, WIDTH + 12, HEIGHT - 1, 1'b1);
        read_req(STORE_SIZE - 1);
        line_req(10, 3, 5, 3, 1'b1);
        read_req(5);
        line_req(3, -4, 3, HEIGHT + 8, 1'b1);
        read_req(3 + WIDTH);
        line_req(3, 20, 3, 2, 1'b0);
        read_req(3);
        line_req(100, 30, 90, 2, 1'b1);
        line_req(WIDTH - 1, 0, 0, HEIGHT - 1, 1'b1);
        read_req(64 + WIDTH);
        line_req(-2048, -2048, 2047, 2047, 1'b1);
        line_req(2047, -2048, -2048, 2047, 1'b1);
        line_req(-2048, 0, 2047, 0, 1'b0);
        read_req(10);
        send_request(noise_req(OP_UNUSED));
        read_req(WIDTH + 2);
        send_request(noise_req(fblr_pkg::OP_CLEAR));
        read_req(STORE_SIZE - 1);
        read_req(0);
        read_req(511);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == QUIET_FROM)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                random_line();
            else if (pick < 90)
                send_request(noise_req(fblr_pkg::OP_READ));
            else if (pick < 94)
                send_request(noise_req(fblr_pkg::OP_CLEAR));
            else
                send_request(noise_req(OP_UNUSED));
        end
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("** framebuffer_line_rasterizer_top: PASSED **");
        else
            $display("** framebuffer_line_rasterizer_top: FAILED **");
        $finish;
    end

endmodule

/* files.f */
design/fblr_pkg.sv
design/framebuffer_line_rasterizer_top.sv
test/fblr_checker.sv
test/framebuffer_line_rasterizer_top_tb.sv
